// File: design/ccpm_pkg.sv
package ccpm_pkg;

  // film-fit modes
  typedef enum logic [1:0] {
    FIT_FILL     = 2'd0,
    FIT_HORIZ    = 2'd1,
    FIT_VERT     = 2'd2,
    FIT_OVERSCAN = 2'd3
  } fit_mode_t;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIT_MODE     = 3'd0,
    CFG_IMAGE_WIDTH  = 3'd1,
    CFG_IMAGE_HEIGHT = 3'd2,
    CFG_LENS_SCALE   = 3'd3,
    CFG_NEAR_PLANE   = 3'd4,
    CFG_FAR_PLANE    = 3'd5
  } cfg_idx_t;

  // register reset values
  localparam fit_mode_t   RST_FIT_MODE   = FIT_HORIZ;
  localparam logic [14:0] RST_IMAGE_DIM  = 15'd128;
  localparam logic [30:0] RST_LENS_SCALE = 31'd65536;
  localparam logic [30:0] RST_NEAR_PLANE = 31'd6554;
  localparam logic [30:0] RST_FAR_PLANE  = 31'd65536000;

  // divider: quotient of 2*num/den kept to this many bits, then rounded
  localparam int QUO_BITS = 34;
  localparam logic [QUO_BITS-1:0] LIM_POS = QUO_BITS'(32'h7FFF_FFFF);
  localparam logic [QUO_BITS-1:0] LIM_NEG = QUO_BITS'(32'h8000_0000);

  // pipeline depth: six operand stages, then the divider stages
  localparam int PRE_LAT  = 6;
  localparam int DIV_LAT  = QUO_BITS + 2;
  localparam int PIPE_LAT = PRE_LAT + DIV_LAT;

  // fixed operand widths
  localparam int PROD_W = 46;   // 31-bit value times 15-bit size
  localparam int SHM_W  = 47;   // 32-bit offset magnitude times 15-bit size
  localparam int DEN0_W = 115;  // 127 * near * scale * film * size
  localparam int DM_W   = 31;   // |far - near|

  // operands carried from stage 3 to the dividers
  typedef struct packed {
    logic [PROD_W-1:0] nx;
    logic [PROD_W-1:0] ny;
    logic [SHM_W-1:0]  sx;
    logic [SHM_W-1:0]  sy;
    logic [PROD_W-1:0] fqx;
    logic [PROD_W-1:0] fqy;
    logic [1:0]        sgn;
  } pipe_carry_t;

endpackage

// File: design/ccpm_if.sv
interface ccpm_in_if;
  import ccpm_pkg::*;
  logic              valid;
  logic              ready;
  logic [30:0]       focal_mm;
  logic [30:0]       back_width;
  logic [30:0]       back_height;
  logic signed [31:0] shift_x;
  logic signed [31:0] shift_y;

  modport source (output valid, focal_mm, back_width, back_height, shift_x, shift_y,
                  input ready);
  modport sink   (input valid, focal_mm, back_width, back_height, shift_x, shift_y,
                  output ready);
endinterface

interface ccpm_out_if;
  import ccpm_pkg::*;
  logic               valid;
  logic               ready;
  logic signed [31:0] m_00;
  logic signed [31:0] m_11;
  logic signed [31:0] m_20;
  logic signed [31:0] m_21;
  logic signed [31:0] m_22;
  logic signed [31:0] m_32;
  logic               saturated;

  modport source (output valid, m_00, m_11, m_20, m_21, m_22, m_32, saturated,
                  input ready);
  modport sink   (input valid, m_00, m_11, m_20, m_21, m_22, m_32, saturated,
                  output ready);
endinterface

interface ccpm_cfg_if;
  import ccpm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/ccpm_div.sv
module ccpm_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic             neg,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [31:0]      res,
  output logic             sat
);
  import ccpm_pkg::*;

  localparam int REM_W = NUM_W + 1;
  localparam int CMP_W = (REM_W > DEN_W + QUO_BITS) ? REM_W : DEN_W + QUO_BITS;

  typedef struct packed {
    logic neg;
    logic dzero;
    logic nzero;
    logic ovf;
  } dflag_t;

  logic [REM_W-1:0]    rem_r [QUO_BITS];
  logic [DEN_W-1:0]    den_r [QUO_BITS];
  logic [QUO_BITS-1:0] quo_r [QUO_BITS+1];
  dflag_t              flg_r [QUO_BITS+1];

  logic [CMP_W-1:0]    num2_w;
  logic                ovf_w;
  logic [QUO_BITS-1:0] rnd_w, lim_w, mag_w;
  logic                sat_w;
  logic [31:0]         res_r;
  logic                sat_r;

  // entry: quotient of 2*num/den must fit in QUO_BITS bits
  assign num2_w = CMP_W'({num, 1'b0});
  assign ovf_w  = (num2_w >> QUO_BITS) >= CMP_W'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {num, 1'b0};
      den_r[0] <= den;
      quo_r[0] <= '0;
      flg_r[0] <= '{neg: neg, dzero: (den == '0), nzero: (num == '0), ovf: ovf_w};
    end
  end

  // one restoring step per stage, most significant quotient bit first
  for (genvar j = 1; j <= QUO_BITS; j++) begin : g_step
    localparam int SH = QUO_BITS - j;
    logic [CMP_W-1:0] rem_w, sub_w;
    logic             take_w;

    always_comb begin
      rem_w  = CMP_W'(rem_r[j-1]);
      sub_w  = CMP_W'(den_r[j-1]) << SH;
      take_w = rem_w >= sub_w;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[j] <= quo_r[j-1] | (QUO_BITS'(take_w) << SH);
        flg_r[j] <= flg_r[j-1];
      end
    end

    if (j < QUO_BITS) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= take_w ? REM_W'(rem_w - sub_w) : rem_r[j-1];
          den_r[j] <= den_r[j-1];
        end
      end
    end
  end

  // round half away from zero, clamp, apply sign
  always_comb begin
    rnd_w = QUO_BITS'(({1'b0, quo_r[QUO_BITS]} + (QUO_BITS+1)'(1)) >> 1);
    lim_w = flg_r[QUO_BITS].neg ? LIM_NEG : LIM_POS;
    sat_w = 1'b0;
    mag_w = rnd_w;
    if (flg_r[QUO_BITS].dzero) begin
      sat_w = 1'b1;
      mag_w = flg_r[QUO_BITS].nzero ? '0 : lim_w;
    end else if (flg_r[QUO_BITS].ovf || (rnd_w > lim_w)) begin
      sat_w = 1'b1;
      mag_w = lim_w;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= flg_r[QUO_BITS].neg ? (32'd0 - mag_w[31:0]) : mag_w[31:0];
      sat_r <= sat_w;
    end
  end

  assign res = res_r;
  assign sat = sat_r;

endmodule

// File: design/camera_projection_matrix.sv
// Perspective projection matrix with film fit. Each input word is one camera
// state; each output word carries the six variable matrix entries in signed
// Q16.16 (FRAC_BITS fraction bits) and a flag that is set when any entry
// clamped or met a zero divisor. The block takes one word per clock while
// no held result stalls the pipeline. Each accepted word
// passes six operand stages that build the exact numerators and denominators
// with 32-bit-class multipliers, a divider entry stage, 34 stages in which
// six parallel dividers resolve one quotient bit each, a rounding stage and
// the output register. Words keep entering while a result waits on the
// output, until the last stage fills. Configuration writes are taken in any
// cycle, but must only be made while no word is in flight.
module camera_projection_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  ccpm_in_if.sink    in_chan,
  ccpm_out_if.source out_chan,
  ccpm_cfg_if.sink   cfg_chan
);
  import ccpm_pkg::*;

  localparam int N00_W = PROD_W + 3 * FRAC_BITS;
  localparam int N20_W = SHM_W + FRAC_BITS + 1;
  localparam int N22_W = 32 + FRAC_BITS;
  localparam int N32_W = 63;

  // configuration registers
  fit_mode_t   fit_mode_r;
  logic [14:0] img_w_r, img_h_r;
  logic [30:0] lens_scale_r, near_r, far_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r   <= RST_FIT_MODE;
      img_w_r      <= RST_IMAGE_DIM;
      img_h_r      <= RST_IMAGE_DIM;
      lens_scale_r <= RST_LENS_SCALE;
      near_r       <= RST_NEAR_PLANE;
      far_r        <= RST_FAR_PLANE;
    end else if (cfg_chan.valid) begin
      unique case (cfg_idx_t'(cfg_chan.index))
        CFG_FIT_MODE:     fit_mode_r   <= fit_mode_t'(cfg_chan.data[1:0]);
        CFG_IMAGE_WIDTH:  img_w_r      <= cfg_chan.data[14:0];
        CFG_IMAGE_HEIGHT: img_h_r      <= cfg_chan.data[14:0];
        CFG_LENS_SCALE:   lens_scale_r <= cfg_chan.data;
        CFG_NEAR_PLANE:   near_r       <= cfg_chan.data;
        CFG_FAR_PLANE:    far_r        <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  assign cfg_chan.ready = 1'b1;

  // pipeline control: advance unless the last stage is blocked by a held result
  logic                en;
  logic [PIPE_LAT-1:0] vld_r;
  logic                out_valid_r;
  logic                out_load;

  assign en            = !out_valid_r || out_chan.ready || !vld_r[PIPE_LAT-1];
  assign in_chan.ready = en;
  assign out_load      = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        vld_r <= {vld_r[PIPE_LAT-2:0], in_chan.valid};
      end
      if (out_load) begin
        out_valid_r <= vld_r[PIPE_LAT-1];
      end
    end
  end

  // stage 1: aspect cross products, offset magnitudes
  logic [PROD_W-1:0] bwh1_r, wbh1_r;
  logic [30:0]       bw1_r, bh1_r, fo1_r;
  logic [31:0]       sxm1_r, sym1_r;
  logic [1:0]        sgn1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      bwh1_r <= PROD_W'(in_chan.back_width) * PROD_W'(img_h_r);
      wbh1_r <= PROD_W'(img_w_r) * PROD_W'(in_chan.back_height);
      bw1_r  <= in_chan.back_width;
      bh1_r  <= in_chan.back_height;
      fo1_r  <= in_chan.focal_mm;
      sxm1_r <= in_chan.shift_x[31] ? (32'd0 - $unsigned(in_chan.shift_x))
                                    : $unsigned(in_chan.shift_x);
      sym1_r <= in_chan.shift_y[31] ? (32'd0 - $unsigned(in_chan.shift_y))
                                    : $unsigned(in_chan.shift_y);
      sgn1_r <= {in_chan.shift_y[31], in_chan.shift_x[31]};
    end
  end

  // stage 2: fit selection
  logic        vert_w;
  logic [30:0] film2_r, fo2_r;
  logic [14:0] px2_r, qx2_r, py2_r, qy2_r;
  logic [31:0] sxm2_r, sym2_r;
  logic [1:0]  sgn2_r;

  always_comb begin
    unique case (fit_mode_r)
      FIT_FILL:     vert_w = bwh1_r > wbh1_r;
      FIT_HORIZ:    vert_w = 1'b0;
      FIT_VERT:     vert_w = 1'b1;
      FIT_OVERSCAN: vert_w = !(bwh1_r > wbh1_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      film2_r <= vert_w ? bh1_r : bw1_r;
      px2_r   <= vert_w ? img_h_r : 15'd1;
      qx2_r   <= vert_w ? img_w_r : 15'd1;
      py2_r   <= vert_w ? 15'd1 : img_w_r;
      qy2_r   <= vert_w ? 15'd1 : img_h_r;
      fo2_r   <= fo1_r;
      sxm2_r  <= sxm1_r;
      sym2_r  <= sym1_r;
      sgn2_r  <= sgn1_r;
    end
  end

  // stage 3: scaled numerators and film denominators, near * scale
  pipe_carry_t car3_r, car4_r, car5_r, car6_r;
  logic [61:0] a3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      car3_r.nx  <= PROD_W'(fo2_r) * PROD_W'(px2_r);
      car3_r.ny  <= PROD_W'(fo2_r) * PROD_W'(py2_r);
      car3_r.sx  <= SHM_W'(sxm2_r) * SHM_W'(px2_r);
      car3_r.sy  <= SHM_W'(sym2_r) * SHM_W'(py2_r);
      car3_r.fqx <= PROD_W'(film2_r) * PROD_W'(qx2_r);
      car3_r.fqy <= PROD_W'(film2_r) * PROD_W'(qy2_r);
      car3_r.sgn <= sgn2_r;
      a3_r       <= 62'(near_r) * 62'(lens_scale_r);
    end
  end

  // stage 4: partial products of (near*scale) * (film*size)
  logic [53:0] ppx4_r [4];
  logic [53:0] ppy4_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      car4_r    <= car3_r;
      ppx4_r[0] <= 54'(a3_r[30:0])  * 54'(car3_r.fqx[22:0]);
      ppx4_r[1] <= 54'(a3_r[30:0])  * 54'(car3_r.fqx[45:23]);
      ppx4_r[2] <= 54'(a3_r[61:31]) * 54'(car3_r.fqx[22:0]);
      ppx4_r[3] <= 54'(a3_r[61:31]) * 54'(car3_r.fqx[45:23]);
      ppy4_r[0] <= 54'(a3_r[30:0])  * 54'(car3_r.fqy[22:0]);
      ppy4_r[1] <= 54'(a3_r[30:0])  * 54'(car3_r.fqy[45:23]);
      ppy4_r[2] <= 54'(a3_r[61:31]) * 54'(car3_r.fqy[22:0]);
      ppy4_r[3] <= 54'(a3_r[61:31]) * 54'(car3_r.fqy[45:23]);
    end
  end

  // stage 5: sum partial products
  logic [107:0] ax5_r, ay5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      car5_r <= car4_r;
      ax5_r  <= 108'(ppx4_r[0]) + (108'(ppx4_r[1]) << 23)
              + (108'(ppx4_r[2]) << 31) + (108'(ppx4_r[3]) << 54);
      ay5_r  <= 108'(ppy4_r[0]) + (108'(ppy4_r[1]) << 23)
              + (108'(ppy4_r[2]) << 31) + (108'(ppy4_r[3]) << 54);
    end
  end

  // stage 6: times 127 (mm/in and half-screen factor), depth operands
  logic [DEN0_W-1:0] dx6_r, dy6_r;
  logic [61:0]       fn6_r;
  logic [31:0]       fs6_r;
  logic [DM_W-1:0]   dm6_r;
  logic              dn6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      car6_r <= car5_r;
      dx6_r  <= (DEN0_W'(ax5_r) << 7) - DEN0_W'(ax5_r);
      dy6_r  <= (DEN0_W'(ay5_r) << 7) - DEN0_W'(ay5_r);
      fn6_r  <= 62'(far_r) * 62'(near_r);
      fs6_r  <= 32'(far_r) + 32'(near_r);
      dn6_r  <= far_r < near_r;
      dm6_r  <= (far_r < near_r) ? (near_r - far_r) : (far_r - near_r);
    end
  end

  // dividers
  logic [31:0] q00_w, q11_w, q20_w, q21_w, q22_w, q32_w;
  logic [5:0]  qsat_w;

  ccpm_div #(.NUM_W(N00_W), .DEN_W(DEN0_W)) u_div_00 (
    .clk(clk), .en(en), .neg(1'b0),
    .num({car6_r.nx, {(3 * FRAC_BITS){1'b0}}}), .den(dx6_r),
    .res(q00_w), .sat(qsat_w[0])
  );

  ccpm_div #(.NUM_W(N00_W), .DEN_W(DEN0_W)) u_div_11 (
    .clk(clk), .en(en), .neg(1'b0),
    .num({car6_r.ny, {(3 * FRAC_BITS){1'b0}}}), .den(dy6_r),
    .res(q11_w), .sat(qsat_w[1])
  );

  ccpm_div #(.NUM_W(N20_W), .DEN_W(PROD_W)) u_div_20 (
    .clk(clk), .en(en), .neg(car6_r.sgn[0]),
    .num({car6_r.sx, {(FRAC_BITS + 1){1'b0}}}), .den(car6_r.fqx),
    .res(q20_w), .sat(qsat_w[2])
  );

  ccpm_div #(.NUM_W(N20_W), .DEN_W(PROD_W)) u_div_21 (
    .clk(clk), .en(en), .neg(car6_r.sgn[1]),
    .num({car6_r.sy, {(FRAC_BITS + 1){1'b0}}}), .den(car6_r.fqy),
    .res(q21_w), .sat(qsat_w[3])
  );

  ccpm_div #(.NUM_W(N22_W), .DEN_W(DM_W)) u_div_22 (
    .clk(clk), .en(en), .neg(dn6_r),
    .num({fs6_r, {FRAC_BITS{1'b0}}}), .den(dm6_r),
    .res(q22_w), .sat(qsat_w[4])
  );

  ccpm_div #(.NUM_W(N32_W), .DEN_W(DM_W)) u_div_32 (
    .clk(clk), .en(en), .neg(dn6_r),
    .num({fn6_r, 1'b0}), .den(dm6_r),
    .res(q32_w), .sat(qsat_w[5])
  );

  // output register
  logic [31:0] m00_r, m11_r, m20_r, m21_r, m22_r, m32_r;
  logic        sat_r;

  always_ff @(posedge clk) begin
    if (out_load && vld_r[PIPE_LAT-1]) begin
      m00_r <= q00_w;
      m11_r <= q11_w;
      m20_r <= q20_w;
      m21_r <= q21_w;
      m22_r <= q22_w;
      m32_r <= q32_w;
      sat_r <= |qsat_w;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.m_00      = m00_r;
  assign out_chan.m_11      = m11_r;
  assign out_chan.m_20      = m20_r;
  assign out_chan.m_21      = m21_r;
  assign out_chan.m_22      = m22_r;
  assign out_chan.m_32      = m32_r;
  assign out_chan.saturated = sat_r;

  // checks
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline valids moved during a stall");

  a_scale_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!m00_r[31] && !m11_r[31]))
    else $error("screen scale entry came out negative");

  a_depth_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !sat_r && (near_r < far_r)) |-> (!m22_r[31] && !m32_r[31]))
    else $error("depth entries negative with near inside far");

endmodule
